FILE: hdl/tmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_pkg: shared types and constants of the TCP MSS clamp
// Request and response payload structs, option-walk modes, status codes and
// the ones-complement checksum adjustment.
// ----------------------------------------------------------------------------
package tmc_pkg;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       last;
    } hdr_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  mss_offset;
        logic [15:0] old_mss;
        logic [15:0] new_mss;
        logic [15:0] new_checksum;
    } hdr_rsp_t;

    typedef enum logic [2:0] {
        MODE_KIND      = 3'd0,
        MODE_LEN_OTHER = 3'd1,
        MODE_LEN_MSS   = 3'd2,
        MODE_SKIP      = 3'd3,
        MODE_MSS_HI    = 3'd4,
        MODE_MSS_LO    = 3'd5,
        MODE_DONE      = 3'd6
    } walk_mode_t;

    localparam logic [2:0] ST_NOT_SYN   = 3'd0;
    localparam logic [2:0] ST_NO_OPTS   = 3'd1;
    localparam logic [2:0] ST_NO_MSS    = 3'd2;
    localparam logic [2:0] ST_MALFORMED = 3'd3;
    localparam logic [2:0] ST_WITHIN    = 3'd4;
    localparam logic [2:0] ST_CLAMPED   = 3'd5;

    // Byte offsets within the TCP header, up to the largest byte position.
    localparam logic [5:0] OFS_DATA_OFFSET = 6'd12;
    localparam logic [5:0] OFS_FLAGS       = 6'd13;
    localparam logic [5:0] OFS_CSUM_HI     = 6'd16;
    localparam logic [5:0] OFS_CSUM_LO     = 6'd17;
    localparam logic [5:0] OFS_OPTIONS     = 6'd20;
    localparam logic [5:0] OFS_LAST        = 6'd63;

    localparam logic [7:0] OPT_END     = 8'd0;
    localparam logic [7:0] OPT_NOP     = 8'd1;
    localparam logic [7:0] OPT_MSS     = 8'd2;
    localparam logic [7:0] OPT_MSS_LEN = 8'd4;
    localparam logic [7:0] OPT_MIN_LEN = 8'd2;

    localparam int unsigned SYN_BIT = 1;

    localparam logic [15:0] MAX_MSS_RESET = 16'd1400;

    // Incremental checksum update: HC' = ~(~HC + ~m + m') with end-around carry.
    function automatic logic [15:0] csum_adjust(input logic [15:0] hc,
                                                input logic [15:0] m_old,
                                                input logic [15:0] m_new);
        logic [17:0] s;
        s = {2'b00, ~hc} + {2'b00, ~m_old} + {2'b00, m_new};
        s = {2'b00, s[15:0]} + {16'h0000, s[17:16]};
        s = {2'b00, s[15:0]} + {16'h0000, s[17:16]};
        return ~s[15:0];
    endfunction

endpackage

FILE: hdl/tcp_mss_clamp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_mss_clamp_core: streaming TCP MSS clamp with checksum update
// Parses one TCP header a byte at a time, walks the options of SYN segments
// and clamps an oversized MSS option, giving one response per header.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                           | Moves
//  --------+-----------------------------------+------------------------------
//  req     | req_valid, req_ready, req_data    | one header byte and last flag
//  rsp     | rsp_valid, rsp_ready, rsp_data    | one result per header
//  cfg     | cfg_wr_en, cfg_wr_data            | max_mss register write
//
// One header byte is taken every cycle unless a final byte is held. A request
// is parsed while it sits in the input register, and the response of a final
// byte is loaded into the output register when that byte moves on from the
// input register. The parse of the registered byte is combinational. A
// response that is not taken holds only a final byte, and the bytes behind
// it wait. Reset clears the parse state and sets max_mss to 1400.
// ----------------------------------------------------------------------------
module tcp_mss_clamp_core #(
    parameter int unsigned MAX_HEADER_BYTES = 60
) (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              req_valid,
    output logic              req_ready,
    input  tmc_pkg::hdr_req_t req_data,

    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tmc_pkg::hdr_rsp_t rsp_data,

    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data
);

    localparam logic [5:0] HDR_CAP = 6'(MAX_HEADER_BYTES);

    // Configuration register.
    logic [15:0] max_mss_reg;

    // Input register stage.
    logic              in_valid_reg;
    tmc_pkg::hdr_req_t in_data_reg;

    // Parse state.
    logic [5:0]          byte_index_reg,    byte_index_next;
    logic                syn_seen_reg,      syn_seen_next;
    logic [5:0]          header_length_reg, header_length_next;
    tmc_pkg::walk_mode_t walk_mode_reg,     walk_mode_next;
    logic [5:0]          skip_left_reg,     skip_left_next;
    logic [15:0]         checksum_held_reg, checksum_held_next;
    logic [15:0]         mss_found_reg,     mss_found_next;
    logic [5:0]          mss_position_reg,  mss_position_next;
    logic [2:0]          walk_status_reg,   walk_status_next;

    // State after the current byte, before the end-of-header clear.
    logic [5:0]          upd_byte_index;
    logic                upd_syn_seen;
    logic [5:0]          upd_header_length;
    tmc_pkg::walk_mode_t upd_walk_mode;
    logic [5:0]          upd_skip_left;
    logic [15:0]         upd_checksum_held;
    logic [15:0]         upd_mss_found;
    logic [5:0]          upd_mss_position;
    logic [2:0]          upd_walk_status;

    // Output register stage.
    logic              rsp_valid_reg;
    tmc_pkg::hdr_rsp_t rsp_data_reg;
    tmc_pkg::hdr_rsp_t rsp_next;

    logic       advance;
    logic [7:0] cur_byte;
    logic [5:0] p;

    // The registered byte moves on unless it is a final byte facing a full,
    // stalled output register.
    assign advance   = in_valid_reg &&
                       (!in_data_reg.last || !rsp_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;
    assign cur_byte  = in_data_reg.header_byte;
    assign p         = byte_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_mss_reg <= tmc_pkg::MAX_MSS_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_mss_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_data_reg <= req_data;
        end
    end

    // Next state of the header parser and option walk.
    always_comb
    begin
        logic [6:0] kind_end;
        logic [8:0] opt_end;
        logic [5:0] skip_len;

        upd_byte_index    = (byte_index_reg == tmc_pkg::OFS_LAST) ?
                            byte_index_reg : byte_index_reg + 6'd1;
        upd_syn_seen      = syn_seen_reg;
        upd_header_length = header_length_reg;
        upd_walk_mode     = walk_mode_reg;
        upd_skip_left     = skip_left_reg;
        upd_checksum_held = checksum_held_reg;
        upd_mss_found     = mss_found_reg;
        upd_mss_position  = mss_position_reg;
        upd_walk_status   = walk_status_reg;

        // End of an option kind byte, and end of the option a length implies.
        kind_end = {1'b0, p} + 7'd1;
        opt_end  = {3'b000, p} - 9'd1 + {1'b0, cur_byte};
        skip_len = 6'(cur_byte - tmc_pkg::OPT_MIN_LEN);

        if (p == tmc_pkg::OFS_DATA_OFFSET)
        begin
            upd_header_length = ({cur_byte[7:4], 2'b00} > HDR_CAP) ?
                                HDR_CAP : {cur_byte[7:4], 2'b00};
        end
        else if (p == tmc_pkg::OFS_FLAGS)
        begin
            upd_syn_seen = cur_byte[tmc_pkg::SYN_BIT];
        end
        else if (p == tmc_pkg::OFS_CSUM_HI)
        begin
            upd_checksum_held = {cur_byte, checksum_held_reg[7:0]};
        end
        else if (p == tmc_pkg::OFS_CSUM_LO)
        begin
            upd_checksum_held = {checksum_held_reg[15:8], cur_byte};
        end
        else if (p >= tmc_pkg::OFS_OPTIONS && p < header_length_reg && syn_seen_reg)
        begin
            case (walk_mode_reg)
                tmc_pkg::MODE_KIND:
                begin
                    if (cur_byte == tmc_pkg::OPT_END)
                    begin
                        upd_walk_status = tmc_pkg::ST_NO_MSS;
                        upd_walk_mode   = tmc_pkg::MODE_DONE;
                    end
                    else if (cur_byte == tmc_pkg::OPT_NOP)
                    begin
                        upd_walk_mode = tmc_pkg::MODE_KIND;
                    end
                    else if (kind_end >= {1'b0, header_length_reg})
                    begin
                        upd_walk_status = tmc_pkg::ST_MALFORMED;
                        upd_walk_mode   = tmc_pkg::MODE_DONE;
                    end
                    else if (cur_byte == tmc_pkg::OPT_MSS)
                    begin
                        upd_walk_mode = tmc_pkg::MODE_LEN_MSS;
                    end
                    else
                    begin
                        upd_walk_mode = tmc_pkg::MODE_LEN_OTHER;
                    end
                end
                tmc_pkg::MODE_LEN_OTHER,
                tmc_pkg::MODE_LEN_MSS:
                begin
                    if (cur_byte < tmc_pkg::OPT_MIN_LEN ||
                        opt_end > {3'b000, header_length_reg})
                    begin
                        upd_walk_status = tmc_pkg::ST_MALFORMED;
                        upd_walk_mode   = tmc_pkg::MODE_DONE;
                    end
                    else if (walk_mode_reg == tmc_pkg::MODE_LEN_MSS &&
                             cur_byte == tmc_pkg::OPT_MSS_LEN)
                    begin
                        upd_mss_position = p + 6'd1;
                        upd_walk_mode    = tmc_pkg::MODE_MSS_HI;
                    end
                    else
                    begin
                        upd_skip_left = skip_len;
                        upd_walk_mode = (skip_len == 6'd0) ?
                                        tmc_pkg::MODE_KIND : tmc_pkg::MODE_SKIP;
                    end
                end
                tmc_pkg::MODE_SKIP:
                begin
                    upd_skip_left = skip_left_reg - 6'd1;
                    if (skip_left_reg == 6'd1)
                    begin
                        upd_walk_mode = tmc_pkg::MODE_KIND;
                    end
                end
                tmc_pkg::MODE_MSS_HI:
                begin
                    upd_mss_found = {cur_byte, 8'h00};
                    upd_walk_mode = tmc_pkg::MODE_MSS_LO;
                end
                tmc_pkg::MODE_MSS_LO:
                begin
                    upd_mss_found   = {mss_found_reg[15:8], cur_byte};
                    upd_walk_status = ({mss_found_reg[15:8], cur_byte} > max_mss_reg) ?
                                      tmc_pkg::ST_CLAMPED : tmc_pkg::ST_WITHIN;
                    upd_walk_mode   = tmc_pkg::MODE_DONE;
                end
                default:
                begin
                    upd_walk_mode = walk_mode_reg;
                end
            endcase
        end

        // A held byte keeps the state; a final byte restarts parsing for the next header.
        if (!advance)
        begin
            byte_index_next    = byte_index_reg;
            syn_seen_next      = syn_seen_reg;
            header_length_next = header_length_reg;
            walk_mode_next     = walk_mode_reg;
            skip_left_next     = skip_left_reg;
            checksum_held_next = checksum_held_reg;
            mss_found_next     = mss_found_reg;
            mss_position_next  = mss_position_reg;
            walk_status_next   = walk_status_reg;
        end
        else if (in_data_reg.last)
        begin
            byte_index_next    = 6'd0;
            syn_seen_next      = 1'b0;
            header_length_next = 6'd0;
            walk_mode_next     = tmc_pkg::MODE_KIND;
            skip_left_next     = 6'd0;
            checksum_held_next = 16'h0000;
            mss_found_next     = 16'h0000;
            mss_position_next  = 6'd0;
            walk_status_next   = tmc_pkg::ST_NOT_SYN;
        end
        else
        begin
            byte_index_next    = upd_byte_index;
            syn_seen_next      = upd_syn_seen;
            header_length_next = upd_header_length;
            walk_mode_next     = upd_walk_mode;
            skip_left_next     = upd_skip_left;
            checksum_held_next = upd_checksum_held;
            mss_found_next     = upd_mss_found;
            mss_position_next  = upd_mss_position;
            walk_status_next   = upd_walk_status;
        end
    end

    // Response for a final byte, taken from the state that byte leaves.
    always_comb
    begin
        logic [2:0] st;

        if (!upd_syn_seen)
        begin
            st = tmc_pkg::ST_NOT_SYN;
        end
        else if (upd_header_length <= tmc_pkg::OFS_OPTIONS)
        begin
            st = tmc_pkg::ST_NO_OPTS;
        end
        else if (upd_walk_mode == tmc_pkg::MODE_DONE)
        begin
            st = upd_walk_status;
        end
        else if (upd_walk_mode == tmc_pkg::MODE_KIND)
        begin
            st = tmc_pkg::ST_NO_MSS;
        end
        else
        begin
            // The header ended part way through an option.
            st = tmc_pkg::ST_MALFORMED;
        end

        rsp_next.status       = st;
        rsp_next.mss_offset   = 6'd0;
        rsp_next.old_mss      = 16'h0000;
        rsp_next.new_mss      = 16'h0000;
        rsp_next.new_checksum = upd_checksum_held;

        if (st inside {tmc_pkg::ST_WITHIN, tmc_pkg::ST_CLAMPED})
        begin
            rsp_next.mss_offset = upd_mss_position;
            rsp_next.old_mss    = upd_mss_found;
            rsp_next.new_mss    = upd_mss_found;
        end
        if (st == tmc_pkg::ST_CLAMPED)
        begin
            rsp_next.new_mss      = max_mss_reg;
            rsp_next.new_checksum = tmc_pkg::csum_adjust(upd_checksum_held,
                                                         upd_mss_found, max_mss_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg    <= 6'd0;
            syn_seen_reg      <= 1'b0;
            header_length_reg <= 6'd0;
            walk_mode_reg     <= tmc_pkg::MODE_KIND;
            skip_left_reg     <= 6'd0;
            checksum_held_reg <= 16'h0000;
            mss_found_reg     <= 16'h0000;
            mss_position_reg  <= 6'd0;
            walk_status_reg   <= tmc_pkg::ST_NOT_SYN;
        end
        else
        begin
            byte_index_reg    <= byte_index_next;
            syn_seen_reg      <= syn_seen_next;
            header_length_reg <= header_length_next;
            walk_mode_reg     <= walk_mode_next;
            skip_left_reg     <= skip_left_next;
            checksum_held_reg <= checksum_held_next;
            mss_found_reg     <= mss_found_next;
            mss_position_reg  <= mss_position_next;
            walk_status_reg   <= walk_status_next;
        end
    end

    // Output register: loaded by a final byte, emptied when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance && in_data_reg.last)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_data_reg.last)
        begin
            rsp_data_reg <= rsp_next;
        end
    end

endmodule

FILE: hdl/tmc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmc_checker: port-level checks for the TCP MSS clamp
// Watches the response channel and checks that results are consistent.
// ----------------------------------------------------------------------------
module tmc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input tmc_pkg::hdr_rsp_t rsp_data
);

    // A response that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response withdrawn before it was taken");

    // Without an MSS option the MSS fields are all zero.
    a_no_mss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != tmc_pkg::ST_WITHIN &&
        rsp_data.status != tmc_pkg::ST_CLAMPED |->
        rsp_data.mss_offset == 6'd0 && rsp_data.old_mss == 16'h0000 &&
        rsp_data.new_mss == 16'h0000)
        else $error("MSS fields set without an MSS option");

    // An unchanged MSS is written back as found; a clamped one only shrinks.
    a_mss_relation: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |->
        (rsp_data.status == tmc_pkg::ST_WITHIN && rsp_data.new_mss == rsp_data.old_mss) ||
        (rsp_data.status == tmc_pkg::ST_CLAMPED && rsp_data.new_mss < rsp_data.old_mss) ||
        (rsp_data.status != tmc_pkg::ST_WITHIN && rsp_data.status != tmc_pkg::ST_CLAMPED))
        else $error("new MSS inconsistent with status");

    // An MSS value lies in the options area, after its kind and length bytes.
    a_mss_offset: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == tmc_pkg::ST_WITHIN ||
                      rsp_data.status == tmc_pkg::ST_CLAMPED) |->
        rsp_data.mss_offset >= 6'd22)
        else $error("MSS offset outside the options area");

    // Status codes stop at clamped.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.status <= tmc_pkg::ST_CLAMPED)
        else $error("undefined status code");

endmodule

bind tcp_mss_clamp_core tmc_checker u_tmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

FILE: test/tb_tcp_mss_clamp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_mss_clamp_core: self-checking bench for the TCP MSS clamp core
// Feeds whole TCP headers byte by byte through the request channel and checks
// every response against a cycle-free predictor of the option walk and the
// incremental checksum update. A directed set of headers covers the corner
// cases, then randomised headers run under several max_mss settings, with
// random gaps on both channels and one stretch that runs without gaps.
// ----------------------------------------------------------------------------
module tb_tcp_mss_clamp_core;

    // Header length cap. The same value is given to the block as a parameter.
    localparam int HDR_CAP = 60;
    // Watchdog: far above the slowest legal run of roughly 1700 requests.
    localparam int CYCLE_LIMIT = 400000;
    // How long the end of the run waits for outstanding responses.
    localparam int DRAIN_LIMIT = 5000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    tmc_pkg::hdr_req_t req_data = '0;
    logic              rsp_valid;
    logic              rsp_ready = 1'b0;
    tmc_pkg::hdr_rsp_t rsp_data;
    logic              cfg_wr_en = 1'b0;
    logic [15:0]       cfg_wr_data = '0;

    // ------------------------------------------------------------------------
    // Scoreboard. It mirrors the parse state of the block, works out the
    // verdict of every header when its final byte is accepted and holds the
    // verdicts until the matching responses come back.
    // ------------------------------------------------------------------------
    class mss_clamp_scoreboard;
        int                  hdr_cap;
        logic [15:0]         mss_limit;
        logic [5:0]          byte_pos;
        bit                  syn_flag;
        logic [5:0]          hdr_len;
        tmc_pkg::walk_mode_t mode;
        logic [5:0]          skip_count;
        logic [15:0]         csum_in;
        logic [15:0]         mss_value;
        logic [5:0]          mss_at;
        logic [2:0]          walk_verdict;
        tmc_pkg::hdr_rsp_t   clamp_verdicts[$];
        int                  errors;

        function new(int cap);
            hdr_cap = cap;
            mss_limit = tmc_pkg::MAX_MSS_RESET;
            errors = 0;
            clear();
        endfunction

        function void clear();
            byte_pos = '0;
            syn_flag = 1'b0;
            hdr_len = '0;
            mode = tmc_pkg::MODE_KIND;
            skip_count = '0;
            csum_in = '0;
            mss_value = '0;
            mss_at = '0;
            walk_verdict = '0;
        endfunction

        function void end_walk(logic [2:0] st);
            walk_verdict = st;
            mode = tmc_pkg::MODE_DONE;
        endfunction

        // Ones-complement update of the checksum for one changed 16-bit word.
        function logic [15:0] patch_checksum(logic [15:0] hc, logic [15:0] m_old,
                                             logic [15:0] m_new);
            int unsigned acc;
            acc = {16'h0000, ~hc} + {16'h0000, ~m_old} + {16'h0000, m_new};
            acc = (acc & 32'h0000FFFF) + (acc >> 16);
            acc = (acc & 32'h0000FFFF) + (acc >> 16);
            return ~acc[15:0];
        endfunction

        function void walk_options(int p, logic [7:0] b);
            int len;
            case (mode)
                tmc_pkg::MODE_KIND:
                begin
                    if (b == tmc_pkg::OPT_END)
                        end_walk(tmc_pkg::ST_NO_MSS);
                    else if (b == tmc_pkg::OPT_NOP)
                        ;
                    else if (p + 1 >= int'(hdr_len))
                        end_walk(tmc_pkg::ST_MALFORMED);
                    else if (b == tmc_pkg::OPT_MSS)
                        mode = tmc_pkg::MODE_LEN_MSS;
                    else
                        mode = tmc_pkg::MODE_LEN_OTHER;
                end
                tmc_pkg::MODE_LEN_OTHER, tmc_pkg::MODE_LEN_MSS:
                begin
                    len = int'(b);
                    if (len < int'(tmc_pkg::OPT_MIN_LEN) || (p - 1) + len > int'(hdr_len))
                        end_walk(tmc_pkg::ST_MALFORMED);
                    else if (mode == tmc_pkg::MODE_LEN_MSS &&
                             len == int'(tmc_pkg::OPT_MSS_LEN))
                    begin
                        mss_at = 6'(p + 1);
                        mode = tmc_pkg::MODE_MSS_HI;
                    end
                    else
                    begin
                        skip_count = 6'(len - int'(tmc_pkg::OPT_MIN_LEN));
                        if (skip_count == 0)
                            mode = tmc_pkg::MODE_KIND;
                        else
                            mode = tmc_pkg::MODE_SKIP;
                    end
                end
                tmc_pkg::MODE_SKIP:
                begin
                    skip_count = skip_count - 6'd1;
                    if (skip_count == 0)
                        mode = tmc_pkg::MODE_KIND;
                end
                tmc_pkg::MODE_MSS_HI:
                begin
                    mss_value = {b, 8'h00};
                    mode = tmc_pkg::MODE_MSS_LO;
                end
                tmc_pkg::MODE_MSS_LO:
                begin
                    mss_value[7:0] = b;
                    if (mss_value > mss_limit)
                        end_walk(tmc_pkg::ST_CLAMPED);
                    else
                        end_walk(tmc_pkg::ST_WITHIN);
                end
                default: ;
            endcase
        endfunction

        // Called for every accepted request.
        function void note_request(tmc_pkg::hdr_req_t r);
            int                p;
            int                hl;
            tmc_pkg::hdr_rsp_t v;
            p = int'(byte_pos);
            if (p == int'(tmc_pkg::OFS_DATA_OFFSET))
            begin
                hl = int'(r.header_byte[7:4]) * 4;
                hdr_len = 6'((hl > hdr_cap) ? hdr_cap : hl);
            end
            else if (p == int'(tmc_pkg::OFS_FLAGS))
                syn_flag = r.header_byte[tmc_pkg::SYN_BIT];
            else if (p == int'(tmc_pkg::OFS_CSUM_HI))
                csum_in[15:8] = r.header_byte;
            else if (p == int'(tmc_pkg::OFS_CSUM_LO))
                csum_in[7:0] = r.header_byte;
            else if (p >= int'(tmc_pkg::OFS_OPTIONS) && p < int'(hdr_len) && syn_flag)
                walk_options(p, r.header_byte);
            if (byte_pos < tmc_pkg::OFS_LAST)
                byte_pos = byte_pos + 6'd1;
            if (!r.last)
                return;

            v = '0;
            v.new_checksum = csum_in;
            if (!syn_flag)
                v.status = tmc_pkg::ST_NOT_SYN;
            else if (hdr_len <= tmc_pkg::OFS_OPTIONS)
                v.status = tmc_pkg::ST_NO_OPTS;
            else if (mode == tmc_pkg::MODE_DONE)
                v.status = walk_verdict;
            else if (mode == tmc_pkg::MODE_KIND)
                v.status = tmc_pkg::ST_NO_MSS;
            else
                v.status = tmc_pkg::ST_MALFORMED;
            if (v.status == tmc_pkg::ST_WITHIN || v.status == tmc_pkg::ST_CLAMPED)
            begin
                v.mss_offset = mss_at;
                v.old_mss = mss_value;
                v.new_mss = (v.status == tmc_pkg::ST_CLAMPED) ? mss_limit : mss_value;
                if (v.status == tmc_pkg::ST_CLAMPED)
                    v.new_checksum = patch_checksum(csum_in, mss_value, mss_limit);
            end
            clamp_verdicts.push_back(v);
            clear();
        endfunction

        task report(string what, int got, int want);
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                     want);
            errors++;
        endtask

        // Called for every accepted response.
        task check_response(tmc_pkg::hdr_rsp_t got);
            tmc_pkg::hdr_rsp_t want;
            if (clamp_verdicts.size() == 0)
            begin
                report("response with nothing outstanding, status", got.status, 0);
                return;
            end
            want = clamp_verdicts.pop_front();
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.mss_offset !== want.mss_offset)
                report("mss_offset", got.mss_offset, want.mss_offset);
            if (got.old_mss !== want.old_mss)
                report("old_mss", got.old_mss, want.old_mss);
            if (got.new_mss !== want.new_mss)
                report("new_mss", got.new_mss, want.new_mss);
            if (got.new_checksum !== want.new_checksum)
                report("new_checksum", got.new_checksum, want.new_checksum);
        endtask
    endclass

    mss_clamp_scoreboard sb;

    logic [7:0] hdr[$];     // header under construction
    int         bytes_sent;
    int         cycles;
    bit         no_idle;    // suppresses gaps on both channels

    tcp_mss_clamp_core #(
        .MAX_HEADER_BYTES(HDR_CAP)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Response side. The handshake is judged on the values present at the
    // edge, and ready for the next cycle is then chosen at random, holding
    // back in about a third of cycles unless the gap-free stretch is running.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp_data);
            rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);
        end
    end

    // Sends one request and returns at the edge that accepts it. Each idle
    // cycle ahead of a request is drawn separately, so that about a third of
    // the cycles are idle; without one, valid stays high into the next
    // request so that it is never lowered and raised in one step.
    task send_byte(input logic [7:0] b, input bit fin);
        tmc_pkg::hdr_req_t r;
        r.header_byte = b;
        r.last = fin;
        if (!no_idle)
        begin
            while ($urandom_range(99) < 34)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(r);
        bytes_sent++;
    endtask

    task send_header();
        for (int i = 0; i < hdr.size(); i++)
            send_byte(hdr[i], i == hdr.size() - 1);
    endtask

    // Fills in the twenty fixed bytes with random content, then forces the
    // data offset, the SYN flag and the checksum.
    task start_header(input bit syn, input logic [3:0] words, input logic [15:0] csum);
        hdr.delete();
        repeat (20) hdr.push_back(8'($urandom));
        hdr[tmc_pkg::OFS_DATA_OFFSET] = {words, 4'($urandom)};
        hdr[tmc_pkg::OFS_FLAGS][tmc_pkg::SYN_BIT] = syn;
        hdr[tmc_pkg::OFS_CSUM_HI] = csum[15:8];
        hdr[tmc_pkg::OFS_CSUM_LO] = csum[7:0];
    endtask

    // The register is only written once every response is in and the
    // pipeline has had time to empty of bytes that give no response.
    task write_limit(input logic [15:0] v);
        req_valid <= 1'b0;
        while (sb.clamp_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.mss_limit = v;
    endtask

    // MSS values cluster around the limit so that both verdicts turn up.
    function logic [15:0] pick_mss();
        case ($urandom_range(5))
            0:       return 16'($urandom);
            1:       return sb.mss_limit;
            2:       return sb.mss_limit + 16'd1;
            3:       return sb.mss_limit - 16'd1;
            4:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Well-formed options area: NOPs, other options, at most one MSS option of length
    // four and sometimes an END followed by padding that the walk must ignore.
    task fill_options(input int words);
        int  hl;
        int  room;
        int  c;
        int  len;
        bit  mss_done;
        logic [15:0] m;
        hl = words * 4;
        mss_done = 1'b0;
        while (hdr.size() < hl)
        begin
            room = hl - hdr.size();
            c = $urandom_range(99);
            if (c < 35 && room >= 4 && !mss_done)
            begin
                m = pick_mss();
                hdr.push_back(tmc_pkg::OPT_MSS);
                hdr.push_back(tmc_pkg::OPT_MSS_LEN);
                hdr.push_back(m[15:8]);
                hdr.push_back(m[7:0]);
                mss_done = 1'b1;
            end
            else if (c < 80 && c >= 55 && room >= 2)
            begin
                len = $urandom_range(2, (room < 10) ? room : 10);
                // Now and then an MSS kind with a length other than four.
                if (len != int'(tmc_pkg::OPT_MSS_LEN) && $urandom_range(4) == 0)
                    hdr.push_back(tmc_pkg::OPT_MSS);
                else
                    hdr.push_back(8'($urandom_range(3, 255)));
                hdr.push_back(8'(len));
                repeat (len - 2) hdr.push_back(8'($urandom));
            end
            else if (c >= 80 && c < 85)
            begin
                hdr.push_back(tmc_pkg::OPT_END);
                while (hdr.size() < hl)
                    hdr.push_back(8'($urandom));
            end
            else
                hdr.push_back(tmc_pkg::OPT_NOP);
        end
    endtask

    // Mostly well-formed SYN headers with random content; the rest are
    // broken versions of them or plain noise.
    task build_random_header();
        int c;
        int words;
        int n;
        c = $urandom_range(99);
        if (c < 85)
        begin
            words = ($urandom_range(3) != 0) ? $urandom_range(6, 9) : $urandom_range(0, 15);
            start_header($urandom_range(9) != 0, 4'(words), 16'($urandom));
            fill_options(words);
            if (c >= 70)
            begin
                if ($urandom_range(1) == 1)
                begin
                    n = $urandom_range(1, hdr.size() - 1);
                    while (hdr.size() > n)
                        void'(hdr.pop_back());
                end
                else if (hdr.size() > 20)
                    hdr[$urandom_range(20, hdr.size() - 1)] = 8'($urandom_range(0, 7));
            end
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 6)) hdr.push_back(8'($urandom));
        end
        else
        begin
            hdr.delete();
            repeat ($urandom_range(1, 70)) hdr.push_back(8'($urandom));
        end
    endtask

    initial
    begin
        logic [15:0] limits[4];
        int          start_bytes;
        int          n;
        int          drain;

        sb = new(HDR_CAP);
        bytes_sent = 0;
        cycles = 0;
        no_idle = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- Directed headers, max_mss at its reset value ------
        // A single byte, and a header that ends before the flags byte.
        hdr.delete();
        hdr.push_back(8'hFF);
        send_header();
        start_header(1'b1, 4'd6, 16'h1234);
        while (hdr.size() > 10)
            void'(hdr.pop_back());
        send_header();
        // Not a SYN segment.
        start_header(1'b0, 4'd6, 16'($urandom));
        hdr.push_back(tmc_pkg::OPT_MSS); hdr.push_back(tmc_pkg::OPT_MSS_LEN);
        hdr.push_back(8'hFF); hdr.push_back(8'hFF);
        send_header();
        // Small data offsets: five words, four words and zero.
        start_header(1'b1, 4'd5, 16'hFFFF);
        send_header();
        start_header(1'b1, 4'd4, 16'h0000);
        send_header();
        start_header(1'b1, 4'd0, 16'($urandom));
        send_header();
        // MSS at its largest, clamped, with both checksum extremes.
        start_header(1'b1, 4'd6, 16'h0000);
        hdr.push_back(tmc_pkg::OPT_MSS); hdr.push_back(tmc_pkg::OPT_MSS_LEN);
        hdr.push_back(8'hFF); hdr.push_back(8'hFF);
        send_header();
        start_header(1'b1, 4'd6, 16'hFFFF);
        hdr.push_back(tmc_pkg::OPT_MSS); hdr.push_back(tmc_pkg::OPT_MSS_LEN);
        hdr.push_back(8'hFF); hdr.push_back(8'hFF);
        send_header();
        // Exactly at the limit, then one above it.
        start_header(1'b1, 4'd6, 16'hFFFF);
        hdr.push_back(tmc_pkg::OPT_MSS); hdr.push_back(tmc_pkg::OPT_MSS_LEN);
        hdr.push_back(8'h05); hdr.push_back(8'h78);
        send_header();
        start_header(1'b1, 4'd6, 16'($urandom));
        hdr.push_back(tmc_pkg::OPT_MSS); hdr.push_back(tmc_pkg::OPT_MSS_LEN);
        hdr.push_back(8'h05); hdr.push_back(8'h79);
        send_header();
        // Option kind in the last byte of the options area.
        start_header(1'b1, 4'd6, 16'($urandom));
        repeat (3) hdr.push_back(tmc_pkg::OPT_NOP);
        hdr.push_back(tmc_pkg::OPT_MSS);
        send_header();
        // Length byte below two, and a length that runs past the header.
        start_header(1'b1, 4'd6, 16'($urandom));
        hdr.push_back(8'd3); hdr.push_back(8'd1);
        hdr.push_back(tmc_pkg::OPT_NOP); hdr.push_back(tmc_pkg::OPT_NOP);
        send_header();
        start_header(1'b1, 4'd6, 16'($urandom));
        hdr.push_back(8'd3); hdr.push_back(8'd8);
        hdr.push_back(8'hAA); hdr.push_back(8'h55);
        send_header();
        // Options area used up by NOPs, and an END ahead of an MSS option.
        start_header(1'b1, 4'd6, 16'($urandom));
        repeat (4) hdr.push_back(tmc_pkg::OPT_NOP);
        send_header();
        start_header(1'b1, 4'd7, 16'($urandom));
        hdr.push_back(tmc_pkg::OPT_NOP); hdr.push_back(tmc_pkg::OPT_END);
        hdr.push_back(tmc_pkg::OPT_MSS); hdr.push_back(tmc_pkg::OPT_MSS_LEN);
        hdr.push_back(8'hFF); hdr.push_back(8'hFF);
        hdr.push_back(8'h00); hdr.push_back(8'h00);
        send_header();
        // Header cut short: waiting for a kind, in a length, in an MSS value.
        start_header(1'b1, 4'd7, 16'($urandom));
        hdr.push_back(tmc_pkg::OPT_NOP);
        send_header();
        start_header(1'b1, 4'd7, 16'($urandom));
        hdr.push_back(8'd3);
        send_header();
        start_header(1'b1, 4'd7, 16'($urandom));
        hdr.push_back(tmc_pkg::OPT_MSS); hdr.push_back(tmc_pkg::OPT_MSS_LEN);
        hdr.push_back(8'hFF);
        send_header();
        // MSS kind with length six is skipped like any other option.
        start_header(1'b1, 4'd8, 16'($urandom));
        hdr.push_back(tmc_pkg::OPT_MSS); hdr.push_back(8'd6);
        repeat (4) hdr.push_back(8'hFF);
        hdr.push_back(tmc_pkg::OPT_NOP); hdr.push_back(tmc_pkg::OPT_NOP);
        send_header();
        // Another option ahead of the MSS option, then bytes past the header.
        start_header(1'b1, 4'd8, 16'($urandom));
        hdr.push_back(8'd3); hdr.push_back(8'd4);
        hdr.push_back(8'h00); hdr.push_back(8'hFF);
        hdr.push_back(tmc_pkg::OPT_MSS); hdr.push_back(tmc_pkg::OPT_MSS_LEN);
        hdr.push_back(8'h40); hdr.push_back(8'h00);
        repeat (10) hdr.push_back(8'($urandom));
        send_header();
        // Largest header with the MSS option in its last four bytes, followed
        // by enough extra bytes to run the byte position into saturation.
        start_header(1'b1, 4'd15, 16'($urandom));
        repeat (36) hdr.push_back(tmc_pkg::OPT_NOP);
        hdr.push_back(tmc_pkg::OPT_MSS); hdr.push_back(tmc_pkg::OPT_MSS_LEN);
        hdr.push_back(8'hAB); hdr.push_back(8'hCD);
        repeat (10) hdr.push_back(8'($urandom));
        send_header();

        // ---------------- Random headers over several limits --------------
        // Each phase starts with a register write, which also makes the
        // sender wait until every outstanding response has come back.
        limits[0] = 16'hFFFF;
        limits[1] = 16'h0000;
        limits[2] = 16'($urandom);
        limits[3] = 16'($urandom_range(536, 1460));
        for (int ph = 0; ph < 4; ph++)
        begin
            write_limit(limits[ph]);
            no_idle = (ph == 2);
            start_bytes = bytes_sent;
            n = 0;
            while (bytes_sent - start_bytes < 270 || n < 12)
            begin
                build_random_header();
                send_header();
                n++;
            end
        end
        no_idle = 1'b0;

        // Let the last responses drain, then keep clocking the block in case
        // something unexpected follows.
        req_valid <= 1'b0;
        drain = 0;
        while (sb.clamp_verdicts.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (sb.clamp_verdicts.size() != 0)
            sb.report("responses still outstanding", sb.clamp_verdicts.size(), 0);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
